FILE: rtl/crc64_pkg.sv
// ----------------------------------------------------------------------------
// crc64_pkg
// Shared constants, the queue item type and the zero-byte advance function
// used to build the CRC-64 XOR matrices at elaboration.
// ----------------------------------------------------------------------------
package crc64_pkg;

  localparam int unsigned CRC_W = 64;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned BYTES_PER_WORD_DEF = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [CRC_W-1:0] CRC_POLY_REFL = 64'hD800_0000_0000_0000;

  // Item handed from the front end to the update stage.
  typedef struct packed {
    logic [CRC_W-1:0]   data_crc;  // CRC of the word's bytes from a zero state
    logic [COUNT_W-1:0] advance;   // bytes the running CRC moves through
    logic               first;
    logic               last;
  } crc64_item_t;

  // Run the reflected shift register over n_bytes zero bytes.
  function automatic logic [CRC_W-1:0] zero_advance(logic [CRC_W-1:0] crc_in,
                                                    int unsigned n_bytes);
    logic [CRC_W-1:0] c;
    c = crc_in;
    for (int unsigned i = 0; i < n_bytes * 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/crc64_if.sv
// ----------------------------------------------------------------------------
// crc64_in_if / crc64_out_if
// Valid/ready channels for message words and finished CRC values.
// ----------------------------------------------------------------------------
interface crc64_in_if;
  logic                                valid;
  logic                                ready;
  logic [crc64_pkg::DATA_W-1:0]        data_word;
  logic [crc64_pkg::COUNT_W-1:0]       byte_count;
  logic                                first_word;
  logic                                last_word;

  modport source (output valid, data_word, byte_count, first_word, last_word,
                  input ready);
  modport sink   (input valid, data_word, byte_count, first_word, last_word,
                  output ready);
endinterface

interface crc64_out_if;
  logic                         valid;
  logic                         ready;
  logic [crc64_pkg::CRC_W-1:0]  crc_value;

  modport source (output valid, crc_value, input ready);
  modport sink   (input valid, crc_value, output ready);
endinterface

FILE: rtl/crc64_front.sv
// ----------------------------------------------------------------------------
// crc64_front
// Accepts message words, clips the byte count, right-aligns the valid bytes
// behind leading zero bytes and folds them through a constant XOR matrix.
// ----------------------------------------------------------------------------
module crc64_front #(
  parameter int unsigned BYTES_PER_WORD = crc64_pkg::BYTES_PER_WORD_DEF
) (
  crc64_in_if.sink                in_ch,
  output logic                    push_valid,
  input  logic                    push_ready,
  output crc64_pkg::crc64_item_t  push_item
);

  localparam int unsigned WORD_BITS = BYTES_PER_WORD * 8;
  localparam int unsigned SHIFT_W = $clog2(BYTES_PER_WORD + 1);

  logic [WORD_BITS-1:0]              padded;
  logic [WORD_BITS-1:0]              masked;
  logic [WORD_BITS-1:0]              aligned;
  logic [crc64_pkg::COUNT_W-1:0]     count_clip;
  logic [SHIFT_W-1:0]                shift_bytes;
  logic [crc64_pkg::CRC_W-1:0]       data_crc;
  logic [crc64_pkg::CRC_W-1:0]       dcol [WORD_BITS];

  // Bytes beyond the input word are zero bytes.
  generate
    if (BYTES_PER_WORD > 8) begin : g_wide
      assign padded = {{(WORD_BITS - crc64_pkg::DATA_W){1'b0}}, in_ch.data_word};
    end else if (BYTES_PER_WORD == 8) begin : g_exact
      assign padded = in_ch.data_word;
    end else begin : g_narrow
      assign padded = in_ch.data_word[WORD_BITS-1:0];
    end
  endgenerate

  // Column b: contribution of message bit b with the word padded to full length.
  generate
    for (genvar b = 0; b < WORD_BITS; b++) begin : g_dcol
      localparam logic [crc64_pkg::CRC_W-1:0] DCOL =
        crc64_pkg::zero_advance(64'(1) << (b % 8), BYTES_PER_WORD - b / 8);
      assign dcol[b] = DCOL;
    end
  endgenerate

  always_comb begin
    if (int'(in_ch.byte_count) > int'(BYTES_PER_WORD)) begin
      count_clip = crc64_pkg::COUNT_W'(BYTES_PER_WORD);
    end else begin
      count_clip = in_ch.byte_count;
    end
    shift_bytes = SHIFT_W'(BYTES_PER_WORD) - SHIFT_W'(count_clip);
    for (int unsigned i = 0; i < BYTES_PER_WORD; i++) begin
      masked[i*8 +: 8] = (i < int'(count_clip)) ? padded[i*8 +: 8] : 8'h00;
    end
    // Leading zero bytes leave a zero-state CRC unchanged.
    aligned = masked << {shift_bytes, 3'b000};
    data_crc = '0;
    for (int unsigned b = 0; b < WORD_BITS; b++) begin
      if (aligned[b]) begin
        data_crc = data_crc ^ dcol[b];
      end
    end
  end

  assign in_ch.ready = push_ready;
  assign push_valid = in_ch.valid;
  assign push_item.data_crc = data_crc;
  assign push_item.advance = count_clip;
  assign push_item.first = in_ch.first_word;
  assign push_item.last = in_ch.last_word;

endmodule

FILE: rtl/crc64_queue.sv
// ----------------------------------------------------------------------------
// crc64_queue
// Short FIFO of prepared items between the front end and the update stage.
// ----------------------------------------------------------------------------
module crc64_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  crc64_pkg::crc64_item_t  push_item,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output crc64_pkg::crc64_item_t  pop_item
);

  localparam int unsigned DEPTH = crc64_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  crc64_pkg::crc64_item_t store [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       fill;
  logic                   push_fire;
  logic                   pop_fire;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_item = store[rd_ptr];
  assign push_fire = push_valid && push_ready;
  assign pop_fire = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        fill <= fill + 1'b1;
      end else if (pop_fire && !push_fire) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      store[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/crc64_back.sv
// ----------------------------------------------------------------------------
// crc64_back
// Advances the running CRC by the word's byte count through a selected
// constant XOR matrix, adds the word's contribution and emits on last.
// ----------------------------------------------------------------------------
module crc64_back #(
  parameter int unsigned BYTES_PER_WORD = crc64_pkg::BYTES_PER_WORD_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  crc64_pkg::crc64_item_t  pop_item,
  crc64_out_if.source             out_ch
);

  localparam int unsigned CRC_W = crc64_pkg::CRC_W;

  logic [CRC_W-1:0] adv_col [BYTES_PER_WORD+1][CRC_W];
  logic [CRC_W-1:0] sel_col [CRC_W];
  logic [CRC_W-1:0] running_crc;
  logic [CRC_W-1:0] crc_base;
  logic [CRC_W-1:0] crc_fold;
  logic [CRC_W-1:0] crc_value;
  logic             out_valid;
  logic             pop_fire;

  // Column c of the matrix for k zero bytes.
  generate
    for (genvar k = 0; k <= BYTES_PER_WORD; k++) begin : g_adv
      for (genvar c = 0; c < CRC_W; c++) begin : g_col
        localparam logic [CRC_W-1:0] ADV = crc64_pkg::zero_advance(64'(1) << c, k);
        assign adv_col[k][c] = ADV;
      end
    end
  endgenerate

  always_comb begin
    for (int unsigned c = 0; c < CRC_W; c++) begin
      sel_col[c] = '0;
      for (int unsigned k = 0; k <= BYTES_PER_WORD; k++) begin
        if (int'(pop_item.advance) == k) begin
          sel_col[c] = adv_col[k][c];
        end
      end
    end
    crc_base = pop_item.first ? '0 : running_crc;
    crc_fold = pop_item.data_crc;
    for (int unsigned c = 0; c < CRC_W; c++) begin
      if (crc_base[c]) begin
        crc_fold = crc_fold ^ sel_col[c];
      end
    end
  end

  // Only a last item needs the output register free.
  assign pop_ready = !pop_item.last || !out_valid || out_ch.ready;
  assign pop_fire = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop_fire && pop_item.last) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (pop_fire) begin
        running_crc <= pop_item.last ? '0 : crc_fold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire && pop_item.last) begin
      crc_value <= crc_fold;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.crc_value = crc_value;

endmodule

FILE: rtl/crc64_reflected_bytes.sv
// ----------------------------------------------------------------------------
// crc64_reflected_bytes
// Reflected CRC-64 (poly 0xD800000000000000, zero init, no final XOR) over
// a message streamed as words of up to BYTES_PER_WORD bytes.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | accept
//  in_ch    | in  | data_word, byte_count, first_word, last_word   | valid & ready
//  out_ch   | out | crc_value                                      | valid & ready
//
//  One word per cycle sustained while no last word waits on a stalled output;
//  the running CRC update is a single XOR matrix in the feedback loop.
//  A result passes the queue register, then the output register, after its
//  last word is taken. Reset clears the queue, the running CRC and out_valid.
//  A stalled output holds only last words; other words keep flowing, and the
//  two-entry queue absorbs the front end while the back end waits.
// ----------------------------------------------------------------------------
module crc64_reflected_bytes #(
  parameter int unsigned BYTES_PER_WORD = crc64_pkg::BYTES_PER_WORD_DEF
) (
  input  logic         clk,
  input  logic         rst,
  crc64_in_if.sink     in_ch,
  crc64_out_if.source  out_ch
);

  logic                    push_valid;
  logic                    push_ready;
  crc64_pkg::crc64_item_t  push_item;
  logic                    pop_valid;
  logic                    pop_ready;
  crc64_pkg::crc64_item_t  pop_item;

  crc64_front #(
    .BYTES_PER_WORD(BYTES_PER_WORD)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  crc64_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  crc64_back #(
    .BYTES_PER_WORD(BYTES_PER_WORD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/crc64_reflected_bytes_test.sv
// ----------------------------------------------------------------------------
// crc64_reflected_bytes_test
// Streams message words into the reflected CRC-64 block under random sender
// bursts and receiver stalls. A bit-serial CRC predictor tracks the running
// value at every accepted word and checks each finished CRC in order.
// ----------------------------------------------------------------------------
module crc64_reflected_bytes_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam logic [crc64_pkg::CRC_W-1:0] ISO_POLY = 64'hD800_0000_0000_0000;

  typedef struct {
    logic [crc64_pkg::DATA_W-1:0]  data;
    logic [crc64_pkg::COUNT_W-1:0] count;
    logic                          first;
    logic                          last;
    bit                            drain;  // hold this request until all CRCs are out
  } word_request_t;

  logic clk;
  logic rst;

  crc64_in_if  in_ch ();
  crc64_out_if out_ch ();

  crc64_reflected_bytes dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  word_request_t                pending_words[$];
  logic [crc64_pkg::CRC_W-1:0]  crc_expected[$];
  logic [crc64_pkg::CRC_W-1:0]  msg_crc;
  int unsigned                  fail_count = 0;
  int unsigned                  burst_left;
  int unsigned                  gap_left;
  int unsigned                  stall_left;
  int unsigned                  rx_mode;
  int unsigned                  rx_cycles;
  int unsigned                  idle_cycles;

  // Fold the valid low bytes of one word into a CRC, one bit at a time.
  function automatic logic [crc64_pkg::CRC_W-1:0] crc64_fold_word(
      logic [crc64_pkg::CRC_W-1:0] crc,
      logic [crc64_pkg::DATA_W-1:0] data,
      logic [crc64_pkg::COUNT_W-1:0] count);
    int unsigned n_bytes;
    n_bytes = (count > 8) ? 8 : count;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      crc[7:0] = crc[7:0] ^ data[i*8 +: 8];
      for (int unsigned b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ ISO_POLY) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  function automatic logic [crc64_pkg::DATA_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_word(logic [crc64_pkg::DATA_W-1:0] data, int unsigned count,
                          bit first, bit last, bit drain);
    word_request_t req;
    req.data = data;
    req.count = count[crc64_pkg::COUNT_W-1:0];
    req.first = first;
    req.last = last;
    req.drain = drain;
    pending_words.push_back(req);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    word_request_t               req;
    logic [crc64_pkg::CRC_W-1:0] crc;
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      msg_crc = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        crc = in_ch.first_word ? '0 : msg_crc;
        crc = crc64_fold_word(crc, in_ch.data_word, in_ch.byte_count);
        if (in_ch.last_word) begin
          crc_expected.push_back(crc);
          msg_crc = '0;
        end else begin
          msg_crc = crc;
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     (!pending_words[0].drain || crc_expected.size() == 0)) begin
          req = pending_words.pop_front();
          in_ch.data_word  <= req.data;
          in_ch.byte_count <= req.count;
          in_ch.first_word <= req.first;
          in_ch.last_word  <= req.last;
          in_ch.valid      <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check finished CRCs and stall on a mode that changes over time.
  always @(posedge clk) begin
    logic [crc64_pkg::CRC_W-1:0] want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      rx_mode = 0;
      rx_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (crc_expected.size() == 0) begin
          $display("%0t: crc_value expected none, actual %h", $time, out_ch.crc_value);
          fail_count++;
        end else begin
          want = crc_expected.pop_front();
          if (out_ch.crc_value !== want) begin
            $display("%0t: crc_value expected %h, actual %h", $time, want,
                     out_ch.crc_value);
            fail_count++;
          end
        end
      end
      rx_cycles++;
      if (rx_cycles % 150 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 40);
          end
        end
      endcase
    end
  end

  // End the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n_words;
    int unsigned count;
    bit          first;
    bit          last;
    bit          drain;

    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_word = '0;
    in_ch.byte_count = '0;
    in_ch.first_word = 1'b0;
    in_ch.last_word = 1'b0;
    out_ch.ready = 1'b0;

    // Words before any first flag continue from the reset value.
    add_word(64'h0123_4567_89AB_CDEF, 8, 1'b0, 1'b0, 1'b0);
    add_word('1, 8, 1'b0, 1'b1, 1'b0);
    add_word('0, 8, 1'b1, 1'b1, 1'b0);
    add_word('1, 8, 1'b1, 1'b1, 1'b0);
    add_word(64'h3837_3635_3433_3231, 8, 1'b1, 1'b0, 1'b0);
    add_word(64'h0000_0000_0000_0039, 1, 1'b0, 1'b1, 1'b0);
    add_word(64'h0000_0000_0000_00FF, 1, 1'b1, 1'b1, 1'b0);
    // Zero count: flags still clear and emit.
    add_word({$urandom, $urandom}, 0, 1'b1, 1'b1, 1'b0);
    add_word({$urandom, $urandom}, 3, 1'b1, 1'b0, 1'b0);
    add_word({$urandom, $urandom}, 0, 1'b0, 1'b1, 1'b0);
    // Counts above eight clip to a full word.
    add_word('1, 9, 1'b1, 1'b1, 1'b0);
    add_word({$urandom, $urandom}, 15, 1'b0, 1'b1, 1'b0);
    add_word({$urandom, $urandom}, 12, 1'b1, 1'b0, 1'b0);
    add_word({$urandom, $urandom}, 10, 1'b0, 1'b1, 1'b0);
    // First flag in mid-message restarts the CRC.
    add_word({$urandom, $urandom}, 5, 1'b1, 1'b0, 1'b0);
    add_word({$urandom, $urandom}, 8, 1'b1, 1'b0, 1'b0);
    add_word({$urandom, $urandom}, 4, 1'b0, 1'b1, 1'b0);
    // After a last word the next message starts fresh without a first flag.
    add_word({$urandom, $urandom}, 7, 1'b0, 1'b0, 1'b0);
    add_word({$urandom, $urandom}, 2, 1'b0, 1'b1, 1'b0);
    add_word({$urandom, $urandom}, 8, 1'b1, 1'b1, 1'b1);
    add_word(64'h8000_0000_0000_0000, 8, 1'b1, 1'b1, 1'b0);
    add_word(64'h0000_0000_0000_0001, 1, 1'b1, 1'b1, 1'b0);
    add_word({$urandom, $urandom}, 6, 1'b0, 1'b0, 1'b0);
    add_word(64'h5555_5555_5555_5555, 11, 1'b0, 1'b1, 1'b0);

    while (pending_words.size() < RANDOM_ITEMS + 24) begin
      drain = ($urandom_range(0, 199) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise word: any count and any flags
        add_word(random_word(), $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), drain);
      end else begin
        n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int unsigned w = 0; w < n_words; w++) begin
          first = (w == 0) && ($urandom_range(0, 9) != 0);
          last = (w == n_words - 1) && ($urandom_range(0, 19) != 0);
          if ($urandom_range(0, 7) == 0) count = $urandom_range(0, 15);
          else if (last) count = $urandom_range(1, 8);
          else count = 8;
          add_word(random_word(), count, first, last, drain && (w == 0));
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_ch.valid) @(posedge clk);
    while (crc_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
